FILE: sv/pgn_pkg.sv
package pgn_pkg;

  localparam int CoordW = 32;
  localparam int ScaleW = 24;
  localparam int OctW   = 4;
  localparam int NoiseW = 21;

  localparam logic [0:0] RegInvScale = 1'b0;
  localparam logic [0:0] RegOctCount = 1'b1;

  localparam logic [7:0] PermRom [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,
    8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,
    8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,
    8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,
    8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,
    8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,
    8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,
    8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,
    8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,
    8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,
    8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
    8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,
    8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
    8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,
    8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  // Gradient sign codes per hash mod 12: 2'b01 = +1, 2'b11 = -1, 2'b00 = 0
  function automatic logic signed [1:0] grad_comp(input logic [3:0] g, input int axis);
    logic signed [1:0] r;
    r = 2'sd0;
    case (axis)
      0: r = (g < 4'd8) ? (g[0] ? -2'sd1 : 2'sd1) : 2'sd0;
      1: r = (g < 4'd4) ? (g[1] ? -2'sd1 : 2'sd1)
           : (g < 4'd8) ? 2'sd0 : (g[0] ? -2'sd1 : 2'sd1);
      default: r = (g < 4'd4) ? 2'sd0
           : (g < 4'd8) ? (g[1] ? -2'sd1 : 2'sd1) : (g[1] ? -2'sd1 : 2'sd1);
    endcase
    return r;
  endfunction

  // Quotient estimate h*21/256 never exceeds h/12, so one subtract fixes the rest
  function automatic logic [3:0] mod12(input logic [7:0] h);
    logic [7:0] q;
    logic [12:0] p;
    logic [7:0] r;
    p = 13'(h) * 13'd21;
    q = 8'(p >> 8);
    r = h - 8'(q * 8'd12);
    if (r >= 8'd12) r = r - 8'd12;
    return r[3:0];
  endfunction

endpackage

FILE: sv/perlin_gradient_noise_3d.sv
// Pipeline stages from start to done_o: scale 2, octave 7, sum 2.
// Throughput: one point per cycle; busy is tied low, set by the
// fully pipelined octave lanes, one per octave.
// Reset: registers return to inverse scale 1.0 and one octave; the
// permutation table is a fixed ROM. The receiver cannot stall.
module perlin_gradient_noise_3d #(
  parameter int OCTAVES_MAX   = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  output logic               done_o,
  output logic signed [20:0] noise_value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [23:0]        cfg_data_i
);
  localparam int F  = FRACTION_BITS;
  localparam int PW = F + 8;
  localparam int NW = F + 4;
  localparam int SW = (NW + 5 > 22) ? NW + 5 : 22;
  localparam int OL = 7;
  localparam int LAT = 2 + OL + 2;

  logic [23:0] scale_q;
  logic [3:0]  oct_q;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 24'd65536;
      oct_q   <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pgn_pkg::RegInvScale: scale_q <= cfg_data_i;
        pgn_pkg::RegOctCount: oct_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic [LAT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[LAT-2:0], start};
  end

  // stage 1: products split as 32x12 halves; stage 2 sums them to 56 bits
  logic signed [43:0] plo_q [3], phi_q [3];
  logic signed [31:0] cin [3];
  assign cin[0] = coord_x_i;
  assign cin[1] = coord_y_i;
  assign cin[2] = coord_z_i;
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      plo_q[k] <= 44'(cin[k]) * 44'($signed({1'b0, scale_q[11:0]}));
      phi_q[k] <= 44'(cin[k]) * 44'($signed({1'b0, scale_q[23:12]}));
    end
  end
  logic signed [55:0] prod_q [3];
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++)
      prod_q[k] <= 56'(plo_q[k]) + (56'(phi_q[k]) <<< 12);
  end

  logic [3*PW-1:0] pos [OCTAVES_MAX];
  logic signed [NW-1:0] on [OCTAVES_MAX];
  for (genvar o = 0; o < OCTAVES_MAX; o++) begin : g_oct
    always_comb begin
      for (int k = 0; k < 3; k++) pos[o][k*PW +: PW] = PW'(prod_q[k] >>> (F + o));
    end
    pgn_octave #(.FracW(F)) u_oct (.clk_i(clk_i), .pos_i(pos[o]), .noise_o(on[o]));
  end

  // octave count for the item, delayed to the sum
  logic [3:0] ocd_q [2+OL];
  always_ff @(posedge clk_i) begin
    ocd_q[0] <= (int'(oct_q) > OCTAVES_MAX) ? 4'(OCTAVES_MAX) : oct_q;
    for (int i = 1; i < 2 + OL; i++) ocd_q[i] <= ocd_q[i-1];
  end

  logic signed [SW-1:0] sum_q;
  always_ff @(posedge clk_i) begin
    logic signed [SW-1:0] s;
    s = '0;
    for (int o = 0; o < OCTAVES_MAX; o++)
      if (4'(o) < ocd_q[1+OL]) s = s + SW'(on[o]);
    sum_q <= s;
  end

  always_ff @(posedge clk_i) begin
    if (sum_q > SW'(1048575)) noise_value_o <= 21'sd1048575;
    else if (sum_q < -SW'(1048576)) noise_value_o <= -21'sd1048576;
    else noise_value_o <= 21'(sum_q);
  end
  assign done_o = vld_q[LAT-1];
endmodule

FILE: sv/pgn_octave.sv
// One octave: cell hashing, gradients, fade, trilinear blend.
module pgn_octave #(
  parameter int FracW = 16
) (
  input  logic                   clk_i,
  input  logic [3*(FracW+8)-1:0] pos_i,
  output logic signed [FracW+3:0] noise_o
);
  localparam int PW = FracW + 8;
  localparam int DW = FracW + 2;  // signed offset t or t-1
  localparam int NW = FracW + 4;  // noise in [-3,3]
  localparam logic signed [FracW+1:0] One = (FracW+2)'(1) <<< FracW;

  logic [7:0]       c [3];
  logic [FracW-1:0] t [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c[k] = pos_i[k*PW+FracW +: 8];
      t[k] = pos_i[k*PW +: FracW];
    end
  end

  // stage 1: perm of z corners
  logic [7:0] pz_q [2];
  logic [7:0] c1_q [3];
  logic [FracW-1:0] t1_q [3];
  always_ff @(posedge clk_i) begin
    for (int iz = 0; iz < 2; iz++) pz_q[iz] <= pgn_pkg::PermRom[8'(c[2] + 8'(iz))];
    c1_q <= c;
    t1_q <= t;
  end

  // stage 2: perm of y; index is up to 9 bits, table repeats every 256
  logic [7:0] py_q [2][2];
  logic [7:0] c2_q;
  logic [FracW-1:0] t2_q [3];
  always_ff @(posedge clk_i) begin
    for (int iy = 0; iy < 2; iy++)
      for (int iz = 0; iz < 2; iz++)
        py_q[iy][iz] <= pgn_pkg::PermRom[8'(c1_q[1] + 8'(iy) + pz_q[iz])];
    c2_q <= c1_q[0];
    t2_q <= t1_q;
  end

  // stage 3: hash and mod 12
  logic [3:0] g3_q [8];
  logic [FracW-1:0] t3_q [3];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++)
      g3_q[i] <= pgn_pkg::mod12(pgn_pkg::PermRom[8'(c2_q + 8'(i >> 2) + py_q[(i>>1)&1][i&1])]);
    t3_q <= t2_q;
  end

  // stage 4: dot products; fade pipeline runs alongside
  logic signed [NW-1:0] n4_q [8];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      logic signed [DW-1:0] dx, dy, dz;
      dx = $signed({2'b00, t3_q[0]}) - (((i >> 2) & 1) != 0 ? One : '0);
      dy = $signed({2'b00, t3_q[1]}) - (((i >> 1) & 1) != 0 ? One : '0);
      dz = $signed({2'b00, t3_q[2]}) - ((i & 1) != 0 ? One : '0);
      n4_q[i] <= NW'(dx * pgn_pkg::grad_comp(g3_q[i], 0))
               + NW'(dy * pgn_pkg::grad_comp(g3_q[i], 1))
               + NW'(dz * pgn_pkg::grad_comp(g3_q[i], 2));
    end
  end

  // fade: f1 t2=rnd(t*t), a=6t-15 ; f2 t3=rnd(t2*t), b=rnd(t*a)+10 ; f3 rnd(t3*b)
  localparam int MW = 2*FracW + 8;
  localparam logic signed [MW-1:0] Half = MW'(1) <<< (FracW-1);
  logic signed [FracW+5:0] fsq1_q [3], fa1_q [3];
  logic [FracW-1:0] ft1_q [3];
  logic signed [FracW+5:0] fc3_q [3], fb2_q [3];
  logic signed [FracW+1:0] fade_q [3];
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      logic signed [MW-1:0] p1, p2, p3, p4;
      logic signed [MW-1:0] f;
      p1 = MW'($signed({1'b0, t[k]})) * MW'($signed({1'b0, t[k]}));
      fsq1_q[k] <= (FracW+6)'((p1 + Half) >>> FracW);
      fa1_q[k]  <= (FracW+6)'(6 * $signed({1'b0, t[k]})) - (FracW+6)'(15 * (1 <<< FracW));
      ft1_q[k]  <= t[k];
      p2 = MW'(fsq1_q[k]) * MW'($signed({1'b0, ft1_q[k]}));
      p3 = MW'(fa1_q[k]) * MW'($signed({1'b0, ft1_q[k]}));
      fc3_q[k] <= (FracW+6)'((p2 + Half) >>> FracW);
      fb2_q[k] <= (FracW+6)'(((p3 + Half) >>> FracW) + MW'(10 * (1 <<< FracW)));
      p4 = MW'(fc3_q[k]) * MW'(fb2_q[k]);
      f = (p4 + Half) >>> FracW;
      fade_q[k] <= (f < 0) ? '0 : (f > MW'(One)) ? One : (FracW+2)'(f);
    end
  end

  // stage 5: x lerps, then y and z lerps in later stages (fade_q is registered alongside g3_q, delayed to match)
  logic signed [FracW+1:0] u4_q, v4_q, v5_q, w4_q, w5_q, w6_q;
  logic signed [NW-1:0] x5_q [4];
  logic signed [NW-1:0] y6_q [2];
  always_ff @(posedge clk_i) begin
    logic signed [MW-1:0] d;
    u4_q <= fade_q[0]; v4_q <= fade_q[1]; w4_q <= fade_q[2];
    v5_q <= v4_q; w5_q <= w4_q; w6_q <= w5_q;
    for (int j = 0; j < 4; j++) begin
      d = MW'(n4_q[4+j] - n4_q[j]) * MW'(u4_q);
      x5_q[j] <= n4_q[j] + NW'((d + Half) >>> FracW);
    end
    for (int j = 0; j < 2; j++) begin
      d = MW'(x5_q[2+j] - x5_q[j]) * MW'(v5_q);
      y6_q[j] <= x5_q[j] + NW'((d + Half) >>> FracW);
    end
    d = MW'(y6_q[1] - y6_q[0]) * MW'(w6_q);
    noise_o <= y6_q[0] + NW'((d + Half) >>> FracW);
  end
endmodule
